### rtl/ssc_pkg.sv
package ssc_pkg;

  localparam int NUM_SLOTS_DEF     = 8;
  localparam int DISPLAY_SLOTS_DEF = 3;

  localparam int MASK_W     = 8;
  localparam int MASK_SEL_W = $clog2(MASK_W);
  localparam int THR_W      = 4;
  localparam int CNT_W      = 4;
  localparam int SLOT_OUT_W = 3;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'd120;
  localparam logic [THR_W-1:0]  THR_RESET  = 4'd5;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MASK_W;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_THR     = 1'd1;

  localparam logic OP_STEP      = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  typedef enum logic [2:0] {
    ACT_IDLE   = 3'd0,
    ACT_EMPTY  = 3'd1,
    ACT_DEFER  = 3'd2,
    ACT_RAN    = 3'd3,
    ACT_FRAME  = 3'd4
  } action_t;

  typedef struct packed {
    logic operation;
    logic task_important;
    logic task_finished;
  } step_item_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  swapped;
  } result_item_t;

endpackage

### rtl/slot_scheduler_with_skip_credit.sv
// Channel   Direction  Handshake                  Payload
// step      in         step_valid / step_ready    step_item_t
// result    out        result_valid / result_ready result_item_t
// cfg       in         cfg_we (no wait)           cfg_index, cfg_data
//
// One transaction per cycle unless stalled: the decision for a step is made in the
// cycle it is accepted and lands in the result register, which is visible the next
// cycle. step_ready is low only while the result register is full and not taken.
// Synchronous reset restores the slot mask, threshold, slot index, skip counters
// and display-ready flag; no clearing pass is needed.
module slot_scheduler_with_skip_credit import ssc_pkg::*; #(
  parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
  parameter int DISPLAY_SLOTS = DISPLAY_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_valid,
  output logic                  step_ready,
  input  step_item_t            step,
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_item_t          result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(NUM_SLOTS + 1);
  localparam int SLOT_W = $clog2(NUM_SLOTS);

  logic [MASK_W-1:0] present_mask;
  logic [THR_W-1:0]  skip_threshold;
  logic [IDX_W-1:0]  slot_index;
  logic              frame_ready;
  logic [CNT_W-1:0]  skip_counts [NUM_SLOTS];

  logic [IDX_W-1:0]  slot_index_next;
  logic              frame_ready_next;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_slot;
  logic [CNT_W-1:0]  cnt_next;
  result_item_t      result_next;
  logic              accept;

  assign step_ready = !result_valid || result_ready;
  assign accept     = step_valid && step_ready;

  ssc_decide #(
    .NUM_SLOTS     (NUM_SLOTS),
    .DISPLAY_SLOTS (DISPLAY_SLOTS)
  ) u_decide (
    .step             (step),
    .slot_index       (slot_index),
    .frame_ready      (frame_ready),
    .present_mask     (present_mask),
    .skip_threshold   (skip_threshold),
    .skip_counts      (skip_counts),
    .slot_index_next  (slot_index_next),
    .frame_ready_next (frame_ready_next),
    .cnt_we           (cnt_we),
    .cnt_slot         (cnt_slot),
    .cnt_next         (cnt_next),
    .result           (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask   <= MASK_RESET;
      skip_threshold <= THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_PRESENT_MASK) begin
        present_mask <= cfg_data[MASK_W-1:0];
      end else if (cfg_index == REG_SKIP_THR) begin
        skip_threshold <= cfg_data[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index  <= '0;
      frame_ready <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        skip_counts[i] <= '0;
      end
    end else if (accept) begin
      slot_index  <= slot_index_next;
      frame_ready <= frame_ready_next;
      if (cnt_we) begin
        skip_counts[cnt_slot] <= cnt_next;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

### rtl/ssc_decide.sv
module ssc_decide import ssc_pkg::*; #(
  parameter int NUM_SLOTS     = NUM_SLOTS_DEF,
  parameter int DISPLAY_SLOTS = DISPLAY_SLOTS_DEF,
  localparam int IDX_W  = $clog2(NUM_SLOTS + 1),
  localparam int SLOT_W = $clog2(NUM_SLOTS)
) (
  input  step_item_t        step,
  input  logic [IDX_W-1:0]  slot_index,
  input  logic              frame_ready,
  input  logic [MASK_W-1:0] present_mask,
  input  logic [THR_W-1:0]  skip_threshold,
  input  logic [CNT_W-1:0]  skip_counts [NUM_SLOTS],
  output logic [IDX_W-1:0]  slot_index_next,
  output logic              frame_ready_next,
  output logic              cnt_we,
  output logic [SLOT_W-1:0] cnt_slot,
  output logic [CNT_W-1:0]  cnt_next,
  output result_item_t      result
);

  logic              wrap;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  cur_inc;
  logic              present;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W:0]    cnt_inc;
  logic              run;
  logic              adv_ready;

  assign wrap      = (slot_index >= IDX_W'(NUM_SLOTS));
  assign cur       = wrap ? '0 : slot_index;
  assign cur_inc   = cur + IDX_W'(1);
  assign adv_ready = (cur_inc == IDX_W'(DISPLAY_SLOTS));
  assign cnt_slot  = cur[SLOT_W-1:0];
  assign cnt       = skip_counts[cnt_slot];
  assign cnt_inc   = {1'b0, cnt} + (CNT_W+1)'(1);
  // slots past the mask width are always empty
  assign present   = ((cur >> MASK_SEL_W) == '0) && present_mask[cur[MASK_SEL_W-1:0]];
  assign run       = (cur < IDX_W'(DISPLAY_SLOTS)) || frame_ready || step.task_important ||
                     (cnt_inc > {1'b0, skip_threshold});

  always_comb begin
    slot_index_next  = slot_index;
    frame_ready_next = frame_ready;
    cnt_we           = 1'b0;
    cnt_next         = cnt;
    result.action    = ACT_IDLE;
    result.slot      = '0;
    result.swapped   = 1'b0;
    if (step.operation == OP_FRAME_END) begin
      result.action    = ACT_FRAME;
      result.swapped   = frame_ready;
      frame_ready_next = 1'b0;
    end else if (wrap && frame_ready) begin
      result.action = ACT_IDLE;
    end else begin
      result.slot     = cur[SLOT_OUT_W-1:0];
      slot_index_next = cur;
      if (!present) begin
        result.action    = ACT_EMPTY;
        slot_index_next  = cur_inc;
        frame_ready_next = frame_ready | adv_ready;
      end else if (run) begin
        result.action = ACT_RAN;
        cnt_we        = 1'b1;
        cnt_next      = (cnt == '0) ? '0 : cnt - CNT_W'(1);
        if (step.task_finished) begin
          slot_index_next  = cur_inc;
          frame_ready_next = frame_ready | adv_ready;
        end
      end else begin
        // defer: count the skip and move on
        result.action   = ACT_DEFER;
        cnt_we          = 1'b1;
        cnt_next        = cnt_inc[CNT_W-1:0];
        slot_index_next = cur_inc;
      end
    end
  end

endmodule
